>>> rtl/core/afj_pkg.sv
`timescale 1ns / 1ps
package afj_pkg;

  localparam int ANGLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int NUM_JOINTS    = 5;
  localparam int NUM_COLS      = 6;
  localparam int NUM_ROWS      = 3;
  localparam int CORDIC_STEPS  = 30;
  localparam int STEPS_PER_CYC = 5;
  localparam int CORDIC_CYCLES = CORDIC_STEPS / STEPS_PER_CYC;
  localparam int CW            = 34;
  localparam int ZW            = 33;
  localparam int PHASE_BITS    = 32;
  localparam int LAST_STEP     = 35;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // Joint lanes of the rotator
  localparam int LANE_BASE     = 0;
  localparam int LANE_SHOULDER = 1;
  localparam int LANE_S23      = 2;
  localparam int LANE_S234     = 3;
  localparam int LANE_WRIST2   = 4;

  typedef enum logic [2:0] {
    REG_UPPER_ARM  = 3'd0,
    REG_FOREARM    = 3'd1,
    REG_SHOULDER   = 3'd2,
    REG_WRIST_ONE  = 3'd3,
    REG_WRIST_TWO  = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } q_hs_t;

  function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    unique case (i)
      5'd0:  r = 33'sd536870912;
      5'd1:  r = 33'sd316933406;
      5'd2:  r = 33'sd167458907;
      5'd3:  r = 33'sd85004756;
      5'd4:  r = 33'sd42667331;
      5'd5:  r = 33'sd21354465;
      5'd6:  r = 33'sd10679838;
      5'd7:  r = 33'sd5340245;
      5'd8:  r = 33'sd2670163;
      5'd9:  r = 33'sd1335087;
      5'd10: r = 33'sd667544;
      5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;
      5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41722;
      5'd15: r = 33'sd20861;
      5'd16: r = 33'sd10430;
      5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2608;
      5'd19: r = 33'sd1304;
      5'd20: r = 33'sd652;
      5'd21: r = 33'sd326;
      5'd22: r = 33'sd163;
      5'd23: r = 33'sd81;
      5'd24: r = 33'sd41;
      5'd25: r = 33'sd20;
      5'd26: r = 33'sd10;
      5'd27: r = 33'sd5;
      5'd28: r = 33'sd3;
      5'd29: r = 33'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/afj_front.sv
`timescale 1ns / 1ps
module afj_front #(
  parameter int ANGLE_BITS = afj_pkg::ANGLE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] req_type,
  input  logic [ANGLE_BITS-1:0] angle_base,
  input  logic [ANGLE_BITS-1:0] angle_shoulder,
  input  logic [ANGLE_BITS-1:0] angle_elbow,
  input  logic [ANGLE_BITS-1:0] angle_wrist_one,
  input  logic [ANGLE_BITS-1:0] angle_wrist_two,
  output afj_pkg::q_hs_t q_hs_out,
  input  logic q_pop,
  output logic [2:0] q_frame,
  output logic [afj_pkg::NUM_JOINTS-1:0][ANGLE_BITS-1:0] q_phase
);
  import afj_pkg::*;

  logic [2:0] frame_mem [2];
  logic [NUM_JOINTS-1:0][ANGLE_BITS-1:0] phase_mem [2];
  logic wr_ptr;
  logic rd_ptr;
  logic [1:0] count;
  logic push;
  logic [2:0] frame_in;
  logic [NUM_JOINTS-1:0][ANGLE_BITS-1:0] phase_in;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;

  // classify: frame number 1..6, out-of-range selectors fold to frame 6
  assign frame_in = (req_type > 3'd5) ? 3'd6 : req_type + 3'd1;

  // joint sums wrap modulo one turn
  always_comb begin
    phase_in[LANE_BASE]     = angle_base;
    phase_in[LANE_SHOULDER] = angle_shoulder;
    phase_in[LANE_S23]      = angle_shoulder + angle_elbow;
    phase_in[LANE_S234]     = angle_shoulder + angle_elbow + angle_wrist_one;
    phase_in[LANE_WRIST2]   = angle_wrist_two;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      frame_mem[wr_ptr] <= frame_in;
      phase_mem[wr_ptr] <= phase_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  assign q_hs_out.valid = (count != 2'd0);
  assign q_hs_out.ready = in_ready;
  assign q_frame        = frame_mem[rd_ptr];
  assign q_phase        = phase_mem[rd_ptr];

endmodule

>>> rtl/core/afj_cordic.sv
`timescale 1ns / 1ps
module afj_cordic #(
  parameter int ANGLE_BITS = afj_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = afj_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [afj_pkg::NUM_JOINTS-1:0][ANGLE_BITS-1:0] phase,
  output logic done,
  output logic signed [FRAC_BITS+1:0] sin_out [afj_pkg::NUM_JOINTS],
  output logic signed [FRAC_BITS+1:0] cos_out [afj_pkg::NUM_JOINTS]
);
  import afj_pkg::*;

  localparam int TRIG_BITS = FRAC_BITS + 2;
  localparam int RSH       = 30 - FRAC_BITS;
  localparam logic signed [CW-1:0] RHALF = CW'(1) <<< (29 - FRAC_BITS);
  localparam logic signed [CW-1:0] ONE   = CW'(1) <<< FRAC_BITS;

  logic signed [CW-1:0] x [NUM_JOINTS];
  logic signed [CW-1:0] y [NUM_JOINTS];
  logic signed [ZW-1:0] z [NUM_JOINTS];
  logic signed [CW-1:0] x_next [NUM_JOINTS];
  logic signed [CW-1:0] y_next [NUM_JOINTS];
  logic signed [ZW-1:0] z_next [NUM_JOINTS];
  logic [1:0] quad [NUM_JOINTS];
  logic [2:0] cnt;
  logic busy;

  // five rotation steps per cycle on every lane
  always_comb begin
    logic signed [CW-1:0] xv, yv, dx, dy;
    logic signed [ZW-1:0] zv;
    logic [4:0] idx;
    for (int l = 0; l < NUM_JOINTS; l++) begin
      xv = x[l];
      yv = y[l];
      zv = z[l];
      for (int j = 0; j < STEPS_PER_CYC; j++) begin
        idx = 5'(int'(cnt) * STEPS_PER_CYC + j);
        dx  = yv >>> idx;
        dy  = xv >>> idx;
        if (!zv[ZW-1]) begin
          xv = xv - dx;
          yv = yv + dy;
          zv = zv - atan_turn(idx);
        end else begin
          xv = xv + dx;
          yv = yv - dy;
          zv = zv + atan_turn(idx);
        end
      end
      x_next[l] = xv;
      y_next[l] = yv;
      z_next[l] = zv;
    end
  end

  always_ff @(posedge clk) begin
    logic [PHASE_BITS-1:0] p;
    if (start) begin
      for (int l = 0; l < NUM_JOINTS; l++) begin
        p = {phase[l], {(PHASE_BITS-ANGLE_BITS){1'b0}}};
        quad[l] <= p[PHASE_BITS-1:PHASE_BITS-2];
        x[l]    <= CORDIC_GAIN;
        y[l]    <= '0;
        z[l]    <= signed'({{(ZW-PHASE_BITS+2){1'b0}}, p[PHASE_BITS-3:0]});
      end
    end else if (busy) begin
      for (int l = 0; l < NUM_JOINTS; l++) begin
        x[l] <= x_next[l];
        y[l] <= y_next[l];
        z[l] <= z_next[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == 3'(CORDIC_CYCLES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

  // round to Q FRAC_BITS, clamp to one, fold in the quadrant
  always_comb begin
    logic signed [CW-1:0] rc, rs;
    logic signed [TRIG_BITS-1:0] c, s;
    for (int l = 0; l < NUM_JOINTS; l++) begin
      rc = (x[l] + RHALF) >>> RSH;
      rs = (y[l] + RHALF) >>> RSH;
      if (rc > ONE) rc = ONE;
      if (rc < -ONE) rc = -ONE;
      if (rs > ONE) rs = ONE;
      if (rs < -ONE) rs = -ONE;
      c = rc[TRIG_BITS-1:0];
      s = rs[TRIG_BITS-1:0];
      unique case (quad[l])
        2'd0: begin cos_out[l] = c;  sin_out[l] = s;  end
        2'd1: begin cos_out[l] = -s; sin_out[l] = c;  end
        2'd2: begin cos_out[l] = -c; sin_out[l] = -s; end
        default: begin cos_out[l] = s; sin_out[l] = -c; end
      endcase
    end
  end

endmodule

>>> rtl/core/afj_back.sv
`timescale 1ns / 1ps
module afj_back #(
  parameter int ANGLE_BITS = afj_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = afj_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  afj_pkg::q_hs_t q_hs_in,
  output logic q_pop,
  input  logic [2:0] q_frame,
  input  logic [afj_pkg::NUM_JOINTS-1:0][ANGLE_BITS-1:0] q_phase,
  input  logic [afj_pkg::NUM_JOINTS-1:0][FRAC_BITS+1:0] lengths,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] column,
  output logic signed [FRAC_BITS+3:0] lin_x,
  output logic signed [FRAC_BITS+3:0] lin_y,
  output logic signed [FRAC_BITS+3:0] lin_z,
  output logic signed [FRAC_BITS+3:0] ang_x,
  output logic signed [FRAC_BITS+3:0] ang_y,
  output logic signed [FRAC_BITS+3:0] ang_z,
  output logic last_column
);
  import afj_pkg::*;

  localparam int LEN_BITS  = FRAC_BITS + 2;
  localparam int OUT_BITS  = FRAC_BITS + 4;
  localparam int TRIG_BITS = FRAC_BITS + 2;
  localparam int IW        = FRAC_BITS + 8;
  localparam logic signed [2*IW-1:0] HALF   = (2*IW)'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [IW-1:0]   SAT_HI = (IW'(1) <<< (OUT_BITS - 1)) - IW'(1);
  localparam logic signed [IW-1:0]   SAT_LO = -(IW'(1) <<< (OUT_BITS - 1));
  localparam logic signed [OUT_BITS-1:0] ONE_OUT = OUT_BITS'(1) <<< FRAC_BITS;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_ROT  = 4'b0010,
    ST_MAC  = 4'b0100,
    ST_HAND = 4'b1000
  } state_t;

  state_t state;
  logic [2:0] frame;
  logic [5:0] step;
  logic rot_done;
  logic signed [TRIG_BITS-1:0] sn_w [NUM_JOINTS];
  logic signed [TRIG_BITS-1:0] cs_w [NUM_JOINTS];
  logic signed [IW-1:0] sn [NUM_JOINTS];
  logic signed [IW-1:0] cs [NUM_JOINTS];

  logic signed [IW-1:0] l2, l3, l4, l5, l6;
  logic signed [IW-1:0] t, u, w, off, tmp, lin42;
  logic signed [IW-1:0] a_r [1:3];
  logic signed [IW-1:0] b_r [1:3];
  logic signed [IW-1:0] lin_p [5];
  logic signed [IW-1:0] lin_q [5];
  logic signed [IW-1:0] ang40, ang41, ang50, ang51;

  logic signed [IW-1:0] op_a, op_b;
  logic signed [2*IW-1:0] prod, rnd;
  logic signed [IW-1:0] m;

  logic signed [OUT_BITS-1:0] bank [NUM_COLS][2*NUM_ROWS];
  logic bank_busy;
  logic [2:0] ecol;
  logic load_bank;

  function automatic logic signed [OUT_BITS-1:0] sat(input logic signed [IW-1:0] v);
    logic signed [IW-1:0] r;
    r = v;
    if (r > SAT_HI) r = SAT_HI;
    if (r < SAT_LO) r = SAT_LO;
    return r[OUT_BITS-1:0];
  endfunction

  function automatic logic signed [IW-1:0] len_of(input logic [LEN_BITS-1:0] v, input logic en);
    return en ? signed'({{(IW-LEN_BITS){1'b0}}, v}) : '0;
  endfunction

  assign q_pop     = (state == ST_IDLE) && q_hs_in.valid;
  assign load_bank = (state == ST_HAND) && !bank_busy;

  afj_cordic #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (q_pop),
    .phase   (q_phase),
    .done    (rot_done),
    .sin_out (sn_w),
    .cos_out (cs_w)
  );

  // links beyond the requested frame count as zero
  assign l2 = len_of(lengths[REG_UPPER_ARM], frame >= 3'd2);
  assign l3 = len_of(lengths[REG_FOREARM],   frame >= 3'd3);
  assign l4 = len_of(lengths[REG_SHOULDER],  frame >= 3'd4);
  assign l5 = len_of(lengths[REG_WRIST_ONE], frame >= 3'd5);
  assign l6 = len_of(lengths[REG_WRIST_TWO], frame >= 3'd6);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      unique case (state)
        ST_IDLE: if (q_pop) state <= ST_ROT;
        ST_ROT: if (rot_done) begin
          state <= ST_MAC;
          step  <= '0;
        end
        ST_MAC: begin
          step <= step + 6'd1;
          if (step == 6'(LAST_STEP)) state <= ST_HAND;
        end
        ST_HAND: if (load_bank) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) frame <= q_frame;
    if (rot_done) begin
      for (int l = 0; l < NUM_JOINTS; l++) begin
        sn[l] <= IW'(sn_w[l]);
        cs[l] <= IW'(cs_w[l]);
      end
    end
  end

  // operand selection for the shared multiplier
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (step)
      6'd0:  begin op_a = sn[LANE_WRIST2]; op_b = sn[LANE_S234]; end
      6'd1:  begin op_a = sn[LANE_WRIST2]; op_b = cs[LANE_S234]; end
      6'd2:  begin op_a = cs[LANE_WRIST2]; op_b = cs[LANE_S234]; end
      6'd3:  begin op_a = l5; op_b = sn[LANE_S234]; end
      6'd4:  begin op_a = l6; op_b = u; end
      6'd5:  begin op_a = l3; op_b = cs[LANE_S23]; end
      6'd6:  begin op_a = l2; op_b = cs[LANE_SHOULDER]; end
      6'd7:  begin op_a = l5; op_b = cs[LANE_S234]; end
      6'd8:  begin op_a = l6; op_b = t; end
      6'd9:  begin op_a = l3; op_b = sn[LANE_S23]; end
      6'd10: begin op_a = l2; op_b = sn[LANE_SHOULDER]; end
      6'd11: begin op_a = l6; op_b = cs[LANE_WRIST2]; end
      6'd12: begin op_a = sn[LANE_BASE]; op_b = a_r[1]; end
      6'd13: begin op_a = cs[LANE_BASE]; op_b = off; end
      6'd14: begin op_a = cs[LANE_BASE]; op_b = a_r[1]; end
      6'd15: begin op_a = sn[LANE_BASE]; op_b = off; end
      6'd16: begin op_a = cs[LANE_BASE]; op_b = b_r[1]; end
      6'd17: begin op_a = sn[LANE_BASE]; op_b = b_r[1]; end
      6'd18: begin op_a = cs[LANE_BASE]; op_b = b_r[2]; end
      6'd19: begin op_a = sn[LANE_BASE]; op_b = b_r[2]; end
      6'd20: begin op_a = cs[LANE_BASE]; op_b = b_r[3]; end
      6'd21: begin op_a = sn[LANE_BASE]; op_b = b_r[3]; end
      6'd22: begin op_a = cs[LANE_BASE]; op_b = w; end
      6'd23: begin op_a = sn[LANE_BASE]; op_b = sn[LANE_WRIST2]; end
      6'd24: begin op_a = l6; op_b = tmp; end
      6'd25: begin op_a = sn[LANE_BASE]; op_b = w; end
      6'd26: begin op_a = cs[LANE_BASE]; op_b = sn[LANE_WRIST2]; end
      6'd27: begin op_a = l6; op_b = tmp; end
      6'd28: begin op_a = cs[LANE_WRIST2]; op_b = sn[LANE_S234]; end
      6'd29: begin op_a = l6; op_b = tmp; end
      6'd30: begin op_a = cs[LANE_BASE]; op_b = sn[LANE_S234]; end
      6'd31: begin op_a = sn[LANE_BASE]; op_b = sn[LANE_S234]; end
      6'd32: begin op_a = cs[LANE_BASE]; op_b = u; end
      6'd33: begin op_a = sn[LANE_BASE]; op_b = cs[LANE_WRIST2]; end
      6'd34: begin op_a = sn[LANE_BASE]; op_b = u; end
      6'd35: begin op_a = cs[LANE_BASE]; op_b = cs[LANE_WRIST2]; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod = op_a * op_b;
  assign rnd  = (prod + HALF) >>> FRAC_BITS;
  assign m    = rnd[IW-1:0];

  // store or accumulate each product into its entry
  always_ff @(posedge clk) begin
    if (state == ST_MAC) begin
      unique case (step)
        6'd0:  t <= m;
        6'd1:  u <= m;
        6'd2:  w <= m;
        6'd3:  a_r[3] <= m;
        6'd4:  a_r[3] <= a_r[3] - m;
        6'd5:  a_r[2] <= a_r[3] + m;
        6'd6:  a_r[1] <= a_r[2] + m;
        6'd7:  b_r[3] <= -m;
        6'd8:  b_r[3] <= b_r[3] - m;
        6'd9:  b_r[2] <= b_r[3] + m;
        6'd10: b_r[1] <= b_r[2] + m;
        6'd11: off <= l4 + m;
        6'd12: lin_p[0] <= -m;
        6'd13: lin_p[0] <= lin_p[0] + m;
        6'd14: lin_q[0] <= m;
        6'd15: lin_q[0] <= lin_q[0] + m;
        6'd16: lin_p[1] <= -m;
        6'd17: lin_q[1] <= -m;
        6'd18: lin_p[2] <= -m;
        6'd19: lin_q[2] <= -m;
        6'd20: lin_p[3] <= -m;
        6'd21: lin_q[3] <= -m;
        6'd22: tmp <= -m;
        6'd23: tmp <= tmp - m;
        6'd24: lin_p[4] <= m;
        6'd25: tmp <= -m;
        6'd26: tmp <= tmp + m;
        6'd27: lin_q[4] <= m;
        6'd28: tmp <= m;
        6'd29: lin42 <= -m;
        6'd30: ang40 <= m;
        6'd31: ang41 <= m;
        6'd32: tmp <= -m;
        6'd33: ang50 <= tmp + m;
        6'd34: tmp <= -m;
        6'd35: ang51 <= tmp - m;
        default: tmp <= tmp;
      endcase
    end
  end

  // result bank: rows are lin x,y,z then ang x,y,z
  always_ff @(posedge clk) begin
    logic signed [IW-1:0] s1, c1, c234;
    if (load_bank) begin
      s1   = sn[LANE_BASE];
      c1   = cs[LANE_BASE];
      c234 = cs[LANE_S234];
      bank[0][0] <= sat(lin_p[0]);
      bank[0][1] <= sat(lin_q[0]);
      bank[0][2] <= '0;
      bank[0][3] <= '0;
      bank[0][4] <= '0;
      bank[0][5] <= ONE_OUT;
      for (int j = 1; j <= 3; j++) begin
        bank[j][0] <= sat(lin_p[j]);
        bank[j][1] <= sat(lin_q[j]);
        bank[j][2] <= sat(a_r[j]);
        bank[j][3] <= (frame > 3'(j)) ? sat(s1) : '0;
        bank[j][4] <= (frame > 3'(j)) ? sat(-c1) : '0;
        bank[j][5] <= '0;
      end
      bank[4][0] <= sat(lin_p[4]);
      bank[4][1] <= sat(lin_q[4]);
      bank[4][2] <= sat(lin42);
      bank[4][3] <= (frame >= 3'd5) ? sat(ang40) : '0;
      bank[4][4] <= (frame >= 3'd5) ? sat(ang41) : '0;
      bank[4][5] <= (frame >= 3'd5) ? sat(-c234) : '0;
      bank[5][0] <= '0;
      bank[5][1] <= '0;
      bank[5][2] <= '0;
      bank[5][3] <= (frame >= 3'd6) ? sat(ang50) : '0;
      bank[5][4] <= (frame >= 3'd6) ? sat(ang51) : '0;
      bank[5][5] <= (frame >= 3'd6) ? sat(-t) : '0;
    end
  end

  // column emitter with output register
  always_ff @(posedge clk) begin
    if (rst) begin
      bank_busy <= 1'b0;
      ecol      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_bank) bank_busy <= 1'b1;
      if (!out_valid || out_ready) begin
        if (bank_busy) begin
          out_valid <= 1'b1;
          if (ecol == 3'(NUM_COLS - 1)) begin
            ecol      <= '0;
            bank_busy <= 1'b0;
          end else begin
            ecol <= ecol + 3'd1;
          end
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((!out_valid || out_ready) && bank_busy) begin
      column      <= ecol;
      lin_x       <= bank[ecol][0];
      lin_y       <= bank[ecol][1];
      lin_z       <= bank[ecol][2];
      ang_x       <= bank[ecol][3];
      ang_y       <= bank[ecol][4];
      ang_z       <= bank[ecol][5];
      last_column <= (ecol == 3'(NUM_COLS - 1));
    end
  end

endmodule

>>> rtl/core/arm_frame_jacobian.sv
`timescale 1ns / 1ps
// A request transfer into an idle block is queued, rotated by the CORDIC, worked
// through 36 products on the single shared multiplier and loaded into the result
// bank before its first column transfer; the other columns follow one per cycle
// while out_ready stays high. The next request is popped after the bank load.
// Reset (rst, synchronous): empties the request queue, idles the sequencer and
// emitter, and clears all five link length registers to zero.
module arm_frame_jacobian #(
  parameter int ANGLE_BITS = afj_pkg::ANGLE_BITS_DEF,
  parameter int FRAC_BITS  = afj_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [2:0] req_type,
  input  logic [ANGLE_BITS-1:0] angle_base,
  input  logic [ANGLE_BITS-1:0] angle_shoulder,
  input  logic [ANGLE_BITS-1:0] angle_elbow,
  input  logic [ANGLE_BITS-1:0] angle_wrist_one,
  input  logic [ANGLE_BITS-1:0] angle_wrist_two,
  output logic out_valid,
  input  logic out_ready,
  output logic [2:0] column,
  output logic signed [FRAC_BITS+3:0] lin_x,
  output logic signed [FRAC_BITS+3:0] lin_y,
  output logic signed [FRAC_BITS+3:0] lin_z,
  output logic signed [FRAC_BITS+3:0] ang_x,
  output logic signed [FRAC_BITS+3:0] ang_y,
  output logic signed [FRAC_BITS+3:0] ang_z,
  output logic last_column,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [FRAC_BITS+1:0] cfg_data
);
  import afj_pkg::*;

  // link lengths, unsigned Q2.FRAC_BITS, indexed by register number
  logic [NUM_JOINTS-1:0][FRAC_BITS+1:0] lengths;
  q_hs_t q_hs;
  logic q_pop;
  logic [2:0] q_frame;
  logic [NUM_JOINTS-1:0][ANGLE_BITS-1:0] q_phase;

  // configuration is always taken; writes beyond the register list drop
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lengths <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_UPPER_ARM: lengths[REG_UPPER_ARM] <= cfg_data;
        REG_FOREARM:   lengths[REG_FOREARM]   <= cfg_data;
        REG_SHOULDER:  lengths[REG_SHOULDER]  <= cfg_data;
        REG_WRIST_ONE: lengths[REG_WRIST_ONE] <= cfg_data;
        REG_WRIST_TWO: lengths[REG_WRIST_TWO] <= cfg_data;
        default: lengths <= lengths;
      endcase
    end
  end

  // front: take the request transfer, fold the frame number, form joint sums,
  // hold in a two-entry queue
  afj_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .req_type        (req_type),
    .angle_base      (angle_base),
    .angle_shoulder  (angle_shoulder),
    .angle_elbow     (angle_elbow),
    .angle_wrist_one (angle_wrist_one),
    .angle_wrist_two (angle_wrist_two),
    .q_hs_out        (q_hs),
    .q_pop           (q_pop),
    .q_frame         (q_frame),
    .q_phase         (q_phase)
  );

  // back: sines and cosines, product sequence, then a result bank that the
  // column emitter drains while the next request is worked on
  afj_back #(.ANGLE_BITS(ANGLE_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_hs_in     (q_hs),
    .q_pop       (q_pop),
    .q_frame     (q_frame),
    .q_phase     (q_phase),
    .lengths     (lengths),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .column      (column),
    .lin_x       (lin_x),
    .lin_y       (lin_y),
    .lin_z       (lin_z),
    .ang_x       (ang_x),
    .ang_y       (ang_y),
    .ang_z       (ang_z),
    .last_column (last_column)
  );

endmodule

>>> tb/arm_frame_jacobian_checker.sv
`timescale 1ns / 1ps
module arm_frame_jacobian_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  req_type,
  input  logic [15:0] angle_base,
  input  logic [15:0] angle_shoulder,
  input  logic [15:0] angle_elbow,
  input  logic [15:0] angle_wrist_one,
  input  logic [15:0] angle_wrist_two,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  column,
  input  logic [19:0] lin_x,
  input  logic [19:0] lin_y,
  input  logic [19:0] lin_z,
  input  logic [19:0] ang_x,
  input  logic [19:0] ang_y,
  input  logic [19:0] ang_z,
  input  logic        last_column,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data,
  output int          fail_count,
  output int          columns_pending,
  output int          columns_checked
);
  import afj_pkg::*;

  typedef struct packed {
    logic [2:0]  col;
    logic [19:0] lx, ly, lz, ax, ay, az;
    logic        last;
  } jac_column_t;

  localparam longint ONE = 64'sd65536;
  localparam longint ATAN_TURN [30] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
    5, 3, 1};

  jac_column_t column_q[$];
  longint      link_len [5];

  function automatic longint fx_mul(longint a, longint b);
    return (a * b + 64'sd32768) >>> 16;
  endfunction

  function automatic longint clamp_unit(longint v);
    return v > ONE ? ONE : (v < -ONE ? -ONE : v);
  endfunction

  function automatic logic [19:0] sat20(longint v);
    if (v > 64'sd524287) v = 64'sd524287;
    if (v < -64'sd524288) v = -64'sd524288;
    return v[19:0];
  endfunction

  // rotate the low 30 phase bits, then fold into the quadrant
  function automatic void turn_sin_cos(input logic [15:0] a, output longint sn, output longint cs);
    logic [31:0] ph;
    longint x, y, z, dx, dy, c, s;
    ph = {a, 16'h0000};
    z  = longint'(ph[29:0]);
    x  = 64'sd652032874;
    y  = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TURN[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TURN[i];
      end
    end
    c = clamp_unit((x + 64'sd8192) >>> 14);
    s = clamp_unit((y + 64'sd8192) >>> 14);
    case (ph[31:30])
      2'd0: begin cs = c;  sn = s;  end
      2'd1: begin cs = -s; sn = c;  end
      2'd2: begin cs = -c; sn = -s; end
      default: begin cs = s; sn = -c; end
    endcase
  endfunction

  task automatic predict_frame(input logic [2:0] rt, input logic [15:0] j1, j2, j3, j4, j5);
    longint lin [6][3];
    longint ang [6][3];
    longint s1, c1, s2, c2, s23, c23, s234, c234, s5, c5;
    longint l2, l3, l4, l5, l6, t, u, w, off;
    longint a [4];
    longint b [4];
    int k;
    jac_column_t e;
    k  = rt > 3'd5 ? 6 : int'(rt) + 1;
    l2 = k >= 2 ? link_len[REG_UPPER_ARM] : 0;
    l3 = k >= 3 ? link_len[REG_FOREARM] : 0;
    l4 = k >= 4 ? link_len[REG_SHOULDER] : 0;
    l5 = k >= 5 ? link_len[REG_WRIST_ONE] : 0;
    l6 = k >= 6 ? link_len[REG_WRIST_TWO] : 0;
    for (int i = 0; i < 6; i++)
      for (int r = 0; r < 3; r++) begin
        lin[i][r] = 0;
        ang[i][r] = 0;
      end
    turn_sin_cos(j1, s1, c1);
    turn_sin_cos(j2, s2, c2);
    turn_sin_cos(16'(j2 + j3), s23, c23);
    turn_sin_cos(16'(j2 + j3 + j4), s234, c234);
    turn_sin_cos(j5, s5, c5);
    t = fx_mul(s5, s234);
    u = fx_mul(s5, c234);
    w = fx_mul(c5, c234);
    a[3] = fx_mul(l5, s234) - fx_mul(l6, u);
    a[2] = a[3] + fx_mul(l3, c23);
    a[1] = a[2] + fx_mul(l2, c2);
    a[0] = a[1];
    b[3] = -fx_mul(l5, c234) - fx_mul(l6, t);
    b[2] = b[3] + fx_mul(l3, s23);
    b[1] = b[2] + fx_mul(l2, s2);
    b[0] = 0;
    off = l4 + fx_mul(l6, c5);
    lin[0][0] = -fx_mul(s1, a[0]) + fx_mul(c1, off);
    lin[0][1] = fx_mul(c1, a[0]) + fx_mul(s1, off);
    for (int j = 1; j <= 3; j++) begin
      lin[j][0] = -fx_mul(c1, b[j]);
      lin[j][1] = -fx_mul(s1, b[j]);
      lin[j][2] = a[j];
      if (k > j) begin
        ang[j][0] = s1;
        ang[j][1] = -c1;
      end
    end
    lin[4][0] = fx_mul(l6, -fx_mul(c1, w) - fx_mul(s1, s5));
    lin[4][1] = fx_mul(l6, -fx_mul(s1, w) + fx_mul(c1, s5));
    lin[4][2] = -fx_mul(l6, fx_mul(c5, s234));
    ang[0][2] = ONE;
    if (k >= 5) begin
      ang[4][0] = fx_mul(c1, s234);
      ang[4][1] = fx_mul(s1, s234);
      ang[4][2] = -c234;
    end
    if (k >= 6) begin
      ang[5][0] = -fx_mul(c1, u) + fx_mul(s1, c5);
      ang[5][1] = -fx_mul(s1, u) - fx_mul(c1, c5);
      ang[5][2] = -t;
    end
    for (int i = 0; i < 6; i++) begin
      e.col  = 3'(i);
      e.lx   = sat20(lin[i][0]);
      e.ly   = sat20(lin[i][1]);
      e.lz   = sat20(lin[i][2]);
      e.ax   = sat20(ang[i][0]);
      e.ay   = sat20(ang[i][1]);
      e.az   = sat20(ang[i][2]);
      e.last = (i == 5);
      column_q.push_back(e);
    end
  endtask

  task automatic compare_field(input string nm, input logic [19:0] want, input logic [19:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, nm,
               $signed(want), $signed(got));
    end
  endtask

  initial begin
    fail_count      = 0;
    columns_checked = 0;
    for (int i = 0; i < 5; i++) link_len[i] = 0;
  end

  assign columns_pending = column_q.size();

  always @(posedge clk) begin
    jac_column_t e;
    if (rst) begin
      for (int i = 0; i < 5; i++) link_len[i] = 0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index <= 3'(REG_WRIST_TWO))
        link_len[cfg_index] = longint'(cfg_data);
      if (in_valid && in_ready)
        predict_frame(req_type, angle_base, angle_shoulder, angle_elbow,
                      angle_wrist_one, angle_wrist_two);
      if (out_valid && out_ready) begin
        if (column_q.size() == 0) begin
          fail_count++;
          $display("%0t: column transfer with nothing expected, actual column %0d",
                   $time, column);
        end else begin
          e = column_q.pop_front();
          columns_checked++;
          compare_field("column", 20'(e.col), 20'(column));
          compare_field("lin_x", e.lx, lin_x);
          compare_field("lin_y", e.ly, lin_y);
          compare_field("lin_z", e.lz, lin_z);
          compare_field("ang_x", e.ax, ang_x);
          compare_field("ang_y", e.ay, ang_y);
          compare_field("ang_z", e.az, ang_z);
          compare_field("last_column", 20'(e.last), 20'(last_column));
        end
      end
    end
  end

endmodule

>>> tb/arm_frame_jacobian_tb.sv
`timescale 1ns / 1ps
module arm_frame_jacobian_tb;
  import afj_pkg::*;

  // an index past the last link register; the block must ignore it
  localparam logic [2:0] SPARE_INDEX = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 80;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  req_type = '0;
  logic [15:0] angle_base = '0, angle_shoulder = '0, angle_elbow = '0;
  logic [15:0] angle_wrist_one = '0, angle_wrist_two = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  column;
  logic signed [19:0] lin_x, lin_y, lin_z, ang_x, ang_y, ang_z;
  logic        last_column;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  int  fail_count, columns_pending, columns_checked;
  int  cycle_count = 0;
  int  frames_sent = 0;
  bit  steady = 1'b0;   // when set, neither side idles

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  arm_frame_jacobian DUT (
    .clk, .rst, .in_valid, .in_ready, .req_type, .angle_base, .angle_shoulder,
    .angle_elbow, .angle_wrist_one, .angle_wrist_two, .out_valid, .out_ready,
    .column, .lin_x, .lin_y, .lin_z, .ang_x, .ang_y, .ang_z, .last_column,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  arm_frame_jacobian_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .req_type, .angle_base, .angle_shoulder,
    .angle_elbow, .angle_wrist_one, .angle_wrist_two, .out_valid, .out_ready,
    .column, .lin_x, .lin_y, .lin_z, .ang_x, .ang_y, .ang_z, .last_column,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .columns_pending, .columns_checked
  );

  // Hold the run to a hard limit so a hung handshake still ends in a verdict
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("arm_frame_jacobian_tb NOT OK");
      $finish;
    end
  end

  // Stall the result side now and then, never while steady is set
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else     out_ready <= steady || ($urandom_range(99) >= 6);
  end

  // Offer one frame request; return once its transfer has happened
  task automatic send_frame(input logic [2:0] rt, input logic [15:0] j1, j2, j3, j4, j5);
    if (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    req_type        <= rt;
    angle_base      <= j1;
    angle_shoulder  <= j2;
    angle_elbow     <= j3;
    angle_wrist_one <= j4;
    angle_wrist_two <= j5;
    do @(posedge clk); while (!in_ready);
    frames_sent++;
  endtask

  // Let every column drain, then give the pipeline time to settle
  task automatic drain_all();
    in_valid <= 1'b0;
    @(posedge clk);
    while (columns_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_link(input logic [2:0] idx, input logic [17:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_links(input logic [17:0] l0, l1, l2, l3, l4);
    drain_all();
    write_link(REG_UPPER_ARM, l0);
    write_link(REG_FOREARM, l1);
    write_link(REG_SHOULDER, l2);
    write_link(REG_WRIST_ONE, l3);
    write_link(REG_WRIST_TWO, l4);
  endtask

  // Favour quadrant edges and full-scale values, otherwise take any angle
  function automatic logic [15:0] pick_angle();
    case ($urandom_range(7))
      0:       return 16'({$urandom_range(3), 14'h0000});
      1:       return 16'(16'({$urandom_range(3), 14'h0000}) + $urandom_range(2) - 1);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_frames(input int n);
    for (int i = 0; i < n; i++)
      send_frame(3'($urandom_range(7)), pick_angle(), pick_angle(), pick_angle(),
                 pick_angle(), pick_angle());
  endtask

  function automatic logic [17:0] pick_len();
    return $urandom_range(3) == 0 ? 18'h3FFFF : 18'($urandom_range(18'h3FFFF));
  endfunction

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset lengths, full-scale links for saturation with a spare-index write, then moderate links
    send_frame(3'd5, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_frame(3'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    set_links(18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF, 18'h3FFFF);
    write_link(SPARE_INDEX, 18'h2AAAA);
    for (int f = 0; f < 8; f++)
      send_frame(3'(f), 16'h4000 * f[1:0], 16'hC000, 16'h8000, 16'h4000, 16'hFFFF);
    send_frame(3'd5, 16'h2000, 16'h2000, 16'h2000, 16'h2000, 16'h2000);
    send_frame(3'd5, 16'hE000, 16'hA000, 16'h6000, 16'h1FFF, 16'h0001);
    send_frame(3'd3, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    set_links(18'h10000, 18'h0C000, 18'h02000, 18'h01800, 18'h01000);
    for (int f = 0; f < 6; f++)
      send_frame(3'(f), 16'h1555, 16'h3000, 16'hD000, 16'h7FFF, 16'h8001);

    // Random phases over several link settings, one with no idling at all
    random_frames(90);
    set_links(pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
    steady = 1'b1;
    random_frames(90);
    steady = 1'b0;
    set_links(18'h3FFFF, 18'h00000, 18'h3FFFF, 18'h00000, 18'h3FFFF);
    random_frames(90);
    set_links(pick_len(), pick_len(), pick_len(), pick_len(), pick_len());
    random_frames(90);
    set_links(18'h00000, 18'h00000, 18'h00000, 18'h00000, 18'h00000);
    random_frames(90);

    drain_all();
    $display("%0d frame requests sent over seven link settings, %0d columns checked",
             frames_sent, columns_checked);
    if (fail_count == 0) begin
      $display("arm_frame_jacobian_tb OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("arm_frame_jacobian_tb NOT OK");
    end
    $finish;
  end

endmodule
